/* hw/rtl/assert_macros.svh */
// Assertion macros for the point subdivider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

/* hw/rtl/crps_pkg.sv */
`timescale 1ns / 1ps

package crps_pkg;

    localparam int PORT_W      = 16;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 7;
    localparam int ACC_W       = COORD_WIDTH + 12;
    localparam int HIST_DEPTH  = 3;
    localparam int HCNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int HIDX_W      = $clog2(HIST_DEPTH);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int STEPS       = 4;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int AXES        = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        acc_t pos;
        acc_t d1;
        acc_t d2;
        acc_t d3;
    } axis_state_t;

    typedef axis_state_t [AXES-1:0] seg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam acc_t COORD_MAX = ACC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam acc_t COORD_MIN = -COORD_MAX - ACC_W'(1);
    localparam acc_t ACC_ONE   = ACC_W'(1);

    function automatic coord_t to_coord(input logic [PORT_W-1:0] v);
        return COORD_WIDTH'(v);
    endfunction

    function automatic axis_state_t axis_coef(input coord_t p0, input coord_t p1,
                                              input coord_t p2, input coord_t p3);
        acc_t e0, e1, e2, e3, a, b, c;
        axis_state_t r;
        e0 = ACC_W'(p0);
        e1 = ACC_W'(p1);
        e2 = ACC_W'(p2);
        e3 = ACC_W'(p3);
        a = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
        b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        c = e2 - e0;
        r.pos = e1 <<< FRAC_BITS;
        r.d1  = a + (b <<< 2) + (c <<< 4);
        r.d2  = (a <<< 2) + (a <<< 1) + (b <<< 3);
        r.d3  = (a <<< 2) + (a <<< 1);
        return r;
    endfunction

    function automatic axis_state_t step_axis(input axis_state_t s);
        axis_state_t r;
        r.pos = s.pos + s.d1;
        r.d1  = s.d1 + s.d2;
        r.d2  = s.d2 + s.d3;
        r.d3  = s.d3;
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] emit_coord(input acc_t v);
        acc_t q;
        q = v >>> FRAC_BITS;
        if (v[ACC_W-1] && (v[FRAC_BITS-1:0] != '0))
            q = q + ACC_ONE;
        if (q > COORD_MAX)
            q = COORD_MAX;
        if (q < COORD_MIN)
            q = COORD_MIN;
        return q[COORD_WIDTH-1:0];
    endfunction

endpackage

/* hw/rtl/crps_in_if.sv */
`timescale 1ns / 1ps

interface crps_in_if
    import crps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] pos_x;
    logic signed [PORT_W-1:0] pos_y;
    logic signed [PORT_W-1:0] pos_z;
    logic                     clear_history;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output clear_history, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input clear_history, output ready);
endinterface

/* hw/rtl/crps_out_if.sv */
`timescale 1ns / 1ps

interface crps_out_if
    import crps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] out_x;
    logic signed [PORT_W-1:0] out_y;
    logic signed [PORT_W-1:0] out_z;
    logic                     last_point;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output last_point, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input last_point, output ready);
endinterface

/* hw/rtl/crps_front.sv */
`timescale 1ns / 1ps

module crps_front
    import crps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    crps_in_if.sink   sample,
    input  q_stat_t   qs,
    output logic      push,
    output seg_t      seg
);

    point_t              hist_reg  [HIST_DEPTH];
    point_t              hist_next [HIST_DEPTH];
    logic [HCNT_W-1:0]   cnt_reg;
    logic [HCNT_W-1:0]   cnt_next;
    point_t              p3;
    logic                accept;

    assign sample.ready = !qs.full;
    assign accept       = sample.valid && sample.ready;

    assign p3.x = to_coord(sample.pos_x);
    assign p3.y = to_coord(sample.pos_y);
    assign p3.z = to_coord(sample.pos_z);

    assign seg[0] = axis_coef(hist_reg[0].x, hist_reg[1].x, hist_reg[2].x, p3.x);
    assign seg[1] = axis_coef(hist_reg[0].y, hist_reg[1].y, hist_reg[2].y, p3.y);
    assign seg[2] = axis_coef(hist_reg[0].z, hist_reg[1].z, hist_reg[2].z, p3.z);

    always_comb
    begin
        hist_next = hist_reg;
        cnt_next  = cnt_reg;
        push      = 1'b0;
        if (accept)
        begin
            if (sample.clear_history)
            begin
                hist_next[0] = p3;
                cnt_next     = HCNT_W'(1);
            end
            else if (cnt_reg < HCNT_W'(HIST_DEPTH))
            begin
                hist_next[cnt_reg[HIDX_W-1:0]] = p3;
                cnt_next = cnt_reg + HCNT_W'(1);
            end
            else
            begin
                // drop the oldest point
                push = 1'b1;
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    hist_next[i] = hist_reg[i + 1];
                hist_next[HIST_DEPTH-1] = p3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            hist_reg <= hist_next;
        end
    end

endmodule

/* hw/rtl/crps_queue.sv */
`timescale 1ns / 1ps

module crps_queue
    import crps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  seg_t    din,
    input  logic    pop,
    output seg_t    head,
    output q_stat_t qs
);

    seg_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] wr_next;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W-1:0] rd_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign head     = mem_reg[rd_reg];
    assign qs.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qs.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
        if (pop)
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hw/rtl/crps_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crps_back
    import crps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     qs,
    input  seg_t        head,
    output logic        pop,
    crps_out_if.source  result
);

    seg_t               work_reg;
    seg_t               src;
    seg_t               nxt;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               fire;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_last_reg;
    logic [PORT_W-1:0]  ox_reg;
    logic [PORT_W-1:0]  oy_reg;
    logic [PORT_W-1:0]  oz_reg;

    assign fire = !qs.empty && (!out_valid_reg || result.ready);
    assign pop  = fire && (step_reg == LAST_STEP);
    assign src  = (step_reg == '0) ? head : work_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            nxt[i] = step_axis(src[i]);
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            step_next      = (step_reg == LAST_STEP) ? '0 : step_reg + STEP_W'(1);
            out_valid_next = 1'b1;
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            work_reg     <= nxt;
            ox_reg       <= PORT_W'(emit_coord(nxt[0].pos));
            oy_reg       <= PORT_W'(emit_coord(nxt[1].pos));
            oz_reg       <= PORT_W'(emit_coord(nxt[2].pos));
            out_last_reg <= (step_reg == LAST_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_x      = ox_reg;
    assign result.out_y      = oy_reg;
    assign result.out_z      = oz_reg;
    assign result.last_point = out_last_reg;

    `ASSERT_CLKD(a_last_wraps, clk, rst_n, out_valid_reg && out_last_reg |-> step_reg == '0, "last point shown mid-segment")
    `ASSERT_CLKD(a_idle_at_start, clk, rst_n, !out_valid_reg |-> step_reg == '0, "output idle mid-segment")
    `ASSERT_CLKD(a_head_held, clk, rst_n, step_reg != '0 |-> !qs.empty, "segment left queue early")
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && qs.empty, "pop from empty queue")

endmodule

/* hw/rtl/catmull_rom_point_subdivider.sv */
`timescale 1ns / 1ps
// An accepted segment transaction is written to the queue; the stepper registers its points.
// The stepper gives one point per cycle while the output is not stalled, four points per
//   segment transaction; transactions that only fill history give no points.
// A 2-entry queue between the coefficient front end and the stepper decouples them.
// Reset: asynchronous, clears history, point count, queue and output valid.

module catmull_rom_point_subdivider
    import crps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    crps_in_if.sink     sample,
    crps_out_if.source  result
);

    q_stat_t qs;
    logic    push;
    logic    pop;
    seg_t    seg;
    seg_t    head;

    crps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .qs     (qs),
        .push   (push),
        .seg    (seg)
    );

    crps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (seg),
        .pop   (pop),
        .head  (head),
        .qs    (qs)
    );

    crps_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qs     (qs),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

/* sim/tb_catmull_rom_point_subdivider.sv */
`timescale 1ns / 1ps

module tb_catmull_rom_point_subdivider;
    import crps_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_ITEMS    = 200;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AFTER  = 60;
    localparam int DRAIN_CYCLES    = 24;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } curve_point_t;

    class subdivision_checker;
        longint       history[HIST_DEPTH][AXES];
        int unsigned  held;
        curve_point_t pending_points[$];
        int unsigned  points_taken;
        int unsigned  clears_seen;
        int unsigned  segments;
        int unsigned  points_checked;
        int unsigned  errors;

        function new();
            foreach (history[i, j])
                history[i][j] = 0;
            held           = 0;
            points_taken   = 0;
            clears_seen    = 0;
            segments       = 0;
            points_checked = 0;
            errors         = 0;
        endfunction

        function coord_t clamp_coord(longint fx);
            longint q;
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            q  = fx / (longint'(1) <<< FRAC_BITS);
            if (q > hi)
                q = hi;
            if (q < lo)
                q = lo;
            return coord_t'(q);
        endfunction

        function void take_point(coord_t nx, coord_t ny, coord_t nz, logic clr);
            longint       fresh[AXES];
            longint       pos;
            longint       d1;
            longint       d2;
            longint       d3;
            longint       a;
            longint       b;
            longint       c;
            coord_t       grid[STEPS][AXES];
            curve_point_t pt;
            fresh[0] = nx;
            fresh[1] = ny;
            fresh[2] = nz;
            points_taken++;
            if (clr)
            begin
                held = 0;
                clears_seen++;
            end
            if (held < HIST_DEPTH)
            begin
                for (int ax = 0; ax < AXES; ax++)
                    history[held][ax] = fresh[ax];
                held++;
                return;
            end
            for (int ax = 0; ax < AXES; ax++)
            begin
                a = -history[0][ax] + 3 * history[1][ax] - 3 * history[2][ax] + fresh[ax];
                b = 2 * history[0][ax] - 5 * history[1][ax] + 4 * history[2][ax] - fresh[ax];
                c = history[2][ax] - history[0][ax];
                pos = history[1][ax] * (longint'(1) <<< FRAC_BITS);
                d1  = a + 4 * b + 16 * c;
                d2  = 6 * a + 8 * b;
                d3  = 6 * a;
                for (int k = 0; k < STEPS; k++)
                begin
                    pos += d1;
                    grid[k][ax] = clamp_coord(pos);
                    d1 += d2;
                    d2 += d3;
                end
            end
            for (int k = 0; k < STEPS; k++)
            begin
                pt.x    = grid[k][0];
                pt.y    = grid[k][1];
                pt.z    = grid[k][2];
                pt.last = (k == STEPS - 1);
                pending_points.push_back(pt);
            end
            for (int ax = 0; ax < AXES; ax++)
            begin
                history[0][ax] = history[1][ax];
                history[1][ax] = history[2][ax];
                history[2][ax] = fresh[ax];
            end
            segments++;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("ERROR @%0t: %s", $time, what);
        endtask

        task match_point(coord_t ox, coord_t oy, coord_t oz, logic olast);
            curve_point_t want;
            if (pending_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected point (%0d,%0d,%0d) last=%0b",
                                          ox, oy, oz, olast));
                return;
            end
            want = pending_points.pop_front();
            points_checked++;
            if (ox !== want.x || oy !== want.y || oz !== want.z || olast !== want.last)
                report_mismatch($sformatf(
                    "point %0d: got (%0d,%0d,%0d) last=%0b, want (%0d,%0d,%0d) last=%0b",
                    points_checked, ox, oy, oz, olast, want.x, want.y, want.z, want.last));
        endtask

        task check_drained();
            if (pending_points.size() != 0)
                report_mismatch($sformatf("%0d interpolated points never arrived",
                                          pending_points.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   hold_off_active;
    bit   hold_off_done;
    int   idle_cycles;

    subdivision_checker curve_check;

    crps_in_if  sample_if ();
    crps_out_if result_if ();

    catmull_rom_point_subdivider dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if.sink),
        .result (result_if.source)
    );

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        sample_if.valid         = 1'b0;
        sample_if.pos_x         = '0;
        sample_if.pos_y         = '0;
        sample_if.pos_z         = '0;
        sample_if.clear_history = 1'b0;
        result_if.ready         = 1'b0;
        hold_off_active         = 1'b0;
        hold_off_done           = 1'b0;
        curve_check             = new();
    end

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [PORT_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return PORT_W'($urandom());
        else if (r < 75)
            return PORT_W'($urandom_range(0, 255) - 128);
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        else if (r < 95)
            return 16'h7fff - PORT_W'($urandom_range(0, 300));
        return 16'h8000 + PORT_W'($urandom_range(0, 300));
    endfunction

    task automatic drive_point(logic [PORT_W-1:0] px, logic [PORT_W-1:0] py,
                               logic [PORT_W-1:0] pz, logic clr, bit no_gap);
        int gap;
        sample_if.valid         <= 1'b1;
        sample_if.pos_x         <= px;
        sample_if.pos_y         <= py;
        sample_if.pos_z         <= pz;
        sample_if.clear_history <= clr;
        do
            @(posedge clk);
        while (!sample_if.ready);
        gap = (no_gap || hold_off_active) ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // input transaction monitor
    always @(posedge clk)
        if (rst_n && sample_if.valid && sample_if.ready)
            curve_check.take_point(coord_t'(sample_if.pos_x[COORD_WIDTH-1:0]),
                                   coord_t'(sample_if.pos_y[COORD_WIDTH-1:0]),
                                   coord_t'(sample_if.pos_z[COORD_WIDTH-1:0]),
                                   sample_if.clear_history);

    // output transaction monitor
    always @(posedge clk)
        if (rst_n && result_if.valid && result_if.ready)
            curve_check.match_point(result_if.out_x, result_if.out_y, result_if.out_z,
                                    result_if.last_point);

    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_off_done && curve_check.points_taken >= HOLD_OFF_AFTER)
            begin
                // hold off long enough for the block to back up into its input
                result_if.ready <= 1'b0;
                hold_off_active = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_active = 1'b0;
                hold_off_done   = 1'b1;
            end
            result_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int calm_left;
        bit clr;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill history, then one plain segment
        drive_point(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
        drive_point(16'd100, -16'sd200, 16'd300, 1'b0, 1'b0);
        drive_point(16'd400, 16'd500, -16'sd600, 1'b0, 1'b0);
        drive_point(-16'sd700, 16'd800, 16'd900, 1'b0, 1'b0);
        // full-scale swings overshoot and saturate
        drive_point(16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b0);
        drive_point(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b0);
        drive_point(16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b0);
        drive_point(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b0);
        drive_point(16'hffff, 16'h0000, 16'h7fff, 1'b0, 1'b1);
        drive_point(16'haaaa, 16'h5555, 16'h8000, 1'b0, 1'b1);
        // clear with full history, then refill with small values
        drive_point(16'd1, 16'd1, 16'd1, 1'b1, 1'b0);
        drive_point(16'd2, -16'sd2, 16'd2, 1'b0, 1'b0);
        drive_point(-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0);
        // small steps exercise truncation toward zero on negatives
        drive_point(-16'sd3, 16'd5, -16'sd7, 1'b0, 1'b0);
        drive_point(-16'sd1, 16'd0, 16'd1, 1'b0, 1'b0);
        drive_point(16'd3, -16'sd4, 16'd0, 1'b0, 1'b0);
        // clear right after a partial fill
        drive_point(16'h5555, 16'haaaa, 16'h0001, 1'b1, 1'b0);
        drive_point(16'h8001, 16'h7ffe, 16'hfffe, 1'b1, 1'b0);
        drive_point(16'h0000, 16'hffff, 16'h8000, 1'b0, 1'b0);
        drive_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
        drive_point(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0);

        calm_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (calm_left == 0 && $urandom_range(0, 15) == 0)
                calm_left = $urandom_range(10, 30);
            clr = ($urandom_range(0, 19) == 0);
            drive_point(pick_coord(), pick_coord(), pick_coord(), clr, calm_left > 0);
            if (calm_left > 0)
                calm_left--;
        end
        sample_if.valid <= 1'b0;

        while (curve_check.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        curve_check.check_drained();

        $display("Run covered %0d input points with %0d history clears, giving %0d segments.",
                 curve_check.points_taken, curve_check.clears_seen, curve_check.segments);
        $display("Checked %0d interpolated points, %0d errors.",
                 curve_check.points_checked, curve_check.errors);
        if (curve_check.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
